// ===== hdl/qrrs_pkg.sv =====
// shared constants and gf(256) arithmetic for the qr reed-solomon encoder
package qrrs_pkg;

    localparam int BYTE_W = 8;
    localparam int EC_COUNT_W = 6;
    localparam int MAX_EC_BYTES_DEF = 32;
    localparam logic [EC_COUNT_W-1:0] EC_COUNT_RESET = 6'd7;
    // field polynomial x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [BYTE_W:0] GF_POLY = 9'h11D;
    localparam logic [BYTE_W-1:0] GF_ONE = 8'h01;

    // multiply by alpha (x) with reduction
    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] shifted;
        shifted = {x[BYTE_W-2:0], 1'b0};
        return x[BYTE_W-1] ? (shifted ^ GF_POLY[BYTE_W-1:0]) : shifted;
    endfunction

    // general product in gf(256), shift-and-add over the bits of b
    function automatic logic [BYTE_W-1:0] gf_mul(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] acc;
        x = a;
        acc = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

// ===== hdl/qrrs_channels.sv =====
// valid/ready channel interfaces of the qr reed-solomon encoder

// message bytes
interface qrrs_msg_if;
    logic                         valid;
    logic                         ready;
    logic [qrrs_pkg::BYTE_W-1:0]  data_byte;
    logic                         block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

// error-correction bytes
interface qrrs_ecc_if;
    logic                         valid;
    logic                         ready;
    logic [qrrs_pkg::BYTE_W-1:0]  ec_byte;
    logic                         ec_last;

    modport source (output valid, output ec_byte, output ec_last, input ready);
    modport sink (input valid, input ec_byte, input ec_last, output ready);
endinterface

// configuration write of ec_count
interface qrrs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [qrrs_pkg::EC_COUNT_W-1:0] ec_count;

    modport source (output valid, output ec_count, input ready);
    modport sink (input valid, input ec_count, output ready);
endinterface

// ===== hdl/qr_reed_solomon_ec_encoder.sv =====
// top level of the qr reed-solomon error-correction encoder over gf(256)
//
// channel  | role   | payload                      | transaction
// ---------+--------+------------------------------+---------------------------------
// msg      | sink   | data_byte[7:0], block_end    | one message byte
// ecc      | source | ec_byte[7:0], ec_last        | one parity byte, high degree first
// cfg      | sink   | ec_count[5:0]                | write of the generator degree
//
// one message byte per cycle while msg.ready holds; the remainder bank updates in the
//   cycle the byte is taken; a block end copies the remainder into a drain bank that
//   emits d bytes at one per cycle while ecc.ready holds; the next block end waits
//   until the drain bank is empty; after reset and after each cfg transaction the
//   generator is rebuilt, one root per cycle over d roots (7 after reset), msg held off
// ecc output comes straight from the drain bank register, so an ecc stall holds it in place
module qr_reed_solomon_ec_encoder #(
    parameter int MAX_EC_BYTES = qrrs_pkg::MAX_EC_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    qrrs_msg_if.sink   msg,
    qrrs_ecc_if.source ecc,
    qrrs_cfg_if.sink   cfg
);

    localparam int CNT_W = $clog2(MAX_EC_BYTES + 1);
    localparam int STEP_W = $clog2(MAX_EC_BYTES);
    localparam int CMP_W = (CNT_W > qrrs_pkg::EC_COUNT_W) ? CNT_W : qrrs_pkg::EC_COUNT_W;
    localparam int BW = qrrs_pkg::BYTE_W;

    // configuration and generator state
    logic [qrrs_pkg::EC_COUNT_W-1:0] ec_count_reg, ec_count_next;
    logic [BW-1:0]                   gen_reg [MAX_EC_BYTES];
    logic [BW-1:0]                   gen_next [MAX_EC_BYTES];
    logic [BW-1:0]                   root_reg, root_next;
    logic [STEP_W-1:0]               step_reg, step_next;
    logic                            building_reg, building_next;

    // division remainder, entry 0 is the highest degree term
    logic [BW-1:0]                   rem_reg [MAX_EC_BYTES];
    logic [BW-1:0]                   rem_next [MAX_EC_BYTES];

    // parity drain bank, entry 0 is on the output
    logic [BW-1:0]                   drain_reg [MAX_EC_BYTES];
    logic [BW-1:0]                   drain_next [MAX_EC_BYTES];
    logic [CNT_W-1:0]                drain_cnt_reg, drain_cnt_next;

    logic [CMP_W-1:0]                ec_wide;
    logic [CNT_W-1:0]                d_eff;
    logic [STEP_W-1:0]               d_last_step;
    logic [BW-1:0]                   fb;
    logic [BW-1:0]                   rem_upd [MAX_EC_BYTES];
    logic [BW-1:0]                   gen_upd [MAX_EC_BYTES];
    logic                            msg_fire;
    logic                            ecc_fire;
    logic                            cfg_fire;

    // effective degree, ec_count clamped to 1..MAX_EC_BYTES
    always_comb
    begin
        ec_wide = CMP_W'(ec_count_reg);
        priority if (ec_wide == '0)
        begin
            d_eff = CNT_W'(1);
        end
        else if (ec_wide > CMP_W'(MAX_EC_BYTES))
        begin
            d_eff = CNT_W'(MAX_EC_BYTES);
        end
        else
        begin
            d_eff = CNT_W'(ec_wide);
        end
        d_last_step = STEP_W'(d_eff - CNT_W'(1));
    end

    // handshakes
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid & cfg.ready;
    // a block end needs the drain bank free
    assign msg.ready = ~building_reg & (~msg.block_end | (drain_cnt_reg == '0));
    assign msg_fire  = msg.valid & msg.ready;
    assign ecc.valid   = (drain_cnt_reg != '0);
    assign ecc.ec_byte = drain_reg[0];
    assign ecc.ec_last = (drain_cnt_reg == CNT_W'(1));
    assign ecc_fire  = ecc.valid & ecc.ready;

    // lfsr step: taps beyond the degree hold zero, so one form serves every degree
    assign fb = msg.data_byte ^ rem_reg[0];
    always_comb
    begin
        for (int i = 0; i < MAX_EC_BYTES - 1; i++)
        begin
            rem_upd[i] = rem_reg[i+1] ^ qrrs_pkg::gf_mul(fb, gen_reg[i]);
        end
        rem_upd[MAX_EC_BYTES-1] = qrrs_pkg::gf_mul(fb, gen_reg[MAX_EC_BYTES-1]);
    end

    // generator step: multiply by (x - root), leading coefficient is an implicit one
    always_comb
    begin
        gen_upd[0] = gen_reg[0] ^ qrrs_pkg::gf_mul(root_reg, qrrs_pkg::GF_ONE);
        for (int k = 1; k < MAX_EC_BYTES; k++)
        begin
            gen_upd[k] = gen_reg[k] ^ qrrs_pkg::gf_mul(root_reg, gen_reg[k-1]);
        end
    end

    // next state
    always_comb
    begin
        ec_count_next  = ec_count_reg;
        gen_next       = gen_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        building_next  = building_reg;
        rem_next       = rem_reg;
        drain_next     = drain_reg;
        drain_cnt_next = drain_cnt_reg;

        if (cfg_fire)
        begin
            // restart the generator build and drop any partial block and any pending parity
            ec_count_next = cfg.ec_count;
            for (int k = 0; k < MAX_EC_BYTES; k++)
            begin
                gen_next[k] = '0;
                rem_next[k] = '0;
            end
            root_next      = qrrs_pkg::GF_ONE;
            step_next      = '0;
            building_next  = 1'b1;
            drain_cnt_next = '0;
        end
        else
        begin
            if (building_reg)
            begin
                gen_next  = gen_upd;
                root_next = qrrs_pkg::gf_xtime(root_reg);
                step_next = STEP_W'(step_reg + STEP_W'(1));
                if (step_reg == d_last_step)
                begin
                    building_next = 1'b0;
                end
            end

            if (msg_fire)
            begin
                if (msg.block_end)
                begin
                    for (int i = 0; i < MAX_EC_BYTES; i++)
                    begin
                        rem_next[i] = '0;
                    end
                end
                else
                begin
                    rem_next = rem_upd;
                end
            end

            if (msg_fire && msg.block_end)
            begin
                drain_next     = rem_upd;
                drain_cnt_next = d_eff;
            end
            else if (ecc_fire)
            begin
                for (int i = 0; i < MAX_EC_BYTES - 1; i++)
                begin
                    drain_next[i] = drain_reg[i+1];
                end
                drain_next[MAX_EC_BYTES-1] = '0;
                drain_cnt_next = CNT_W'(drain_cnt_reg - CNT_W'(1));
            end
        end
    end

    // control and remainder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_count_reg  <= qrrs_pkg::EC_COUNT_RESET;
            root_reg      <= qrrs_pkg::GF_ONE;
            step_reg      <= '0;
            building_reg  <= 1'b1;
            drain_cnt_reg <= '0;
            for (int k = 0; k < MAX_EC_BYTES; k++)
            begin
                gen_reg[k] <= '0;
                rem_reg[k] <= '0;
            end
        end
        else
        begin
            ec_count_reg  <= ec_count_next;
            root_reg      <= root_next;
            step_reg      <= step_next;
            building_reg  <= building_next;
            drain_cnt_reg <= drain_cnt_next;
            gen_reg       <= gen_next;
            rem_reg       <= rem_next;
        end
    end

    // drain bank payload
    always_ff @(posedge clk)
    begin
        drain_reg <= drain_next;
    end

`ifndef SYNTHESIS
    a_build_no_drain : assert property (@(posedge clk) disable iff (!rst_n)
        building_reg |-> drain_cnt_reg == '0)
        else $error("parity output pending during generator build");

    a_block_end_loads : assert property (@(posedge clk) disable iff (!rst_n)
        msg_fire && msg.block_end && !cfg_fire |=> drain_cnt_reg == $past(d_eff))
        else $error("block end did not load d parity bytes");

    a_rem_top_zero : assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg[MAX_EC_BYTES-1] != '0 |-> d_eff == CNT_W'(MAX_EC_BYTES))
        else $error("remainder term beyond degree is nonzero");

    a_drain_bound : assert property (@(posedge clk) disable iff (!rst_n)
        drain_cnt_reg <= d_eff)
        else $error("drain count exceeds degree");
`endif

endmodule

// ===== tb/sv/qrrs_ec_checker.sv =====
// parity predictor and scoreboard watching the channels of the qr reed-solomon encoder
module qrrs_ec_checker (
    input  logic clk,
    input  logic rst_n,
    qrrs_msg_if  msg,
    qrrs_ecc_if  ecc,
    qrrs_cfg_if  cfg,
    output int   errors,
    output int   pending
);
    import qrrs_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] ec_byte;
        logic              ec_last;
    } parity_t;

    parity_t           parity_queue [$];
    logic [BYTE_W-1:0] rem_bank [MAX_EC_BYTES_DEF];
    logic [BYTE_W-1:0] gen_taps [MAX_EC_BYTES_DEF];
    int                degree;
    int                mismatch_total = 0;
    int                queue_depth = 0;

    assign errors = mismatch_total;
    assign pending = queue_depth;

    // horner form over the bits of a, msb first
    function automatic logic [BYTE_W-1:0] field_mul(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] acc;
        acc = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            acc = acc[BYTE_W-1] ? ({acc[BYTE_W-2:0], 1'b0} ^ GF_POLY[BYTE_W-1:0])
                                : {acc[BYTE_W-2:0], 1'b0};
            if (a[i])
            begin
                acc = acc ^ b;
            end
        end
        return acc;
    endfunction

    function automatic int clamp_degree(input logic [EC_COUNT_W-1:0] v);
        if (v < 1)
        begin
            return 1;
        end
        if (v > MAX_EC_BYTES_DEF)
        begin
            return MAX_EC_BYTES_DEF;
        end
        return int'(v);
    endfunction

    // new degree: rebuild generator taps, drop the partial remainder
    task automatic load_degree(input logic [EC_COUNT_W-1:0] v);
        logic [BYTE_W-1:0] poly [MAX_EC_BYTES_DEF+1];
        logic [BYTE_W-1:0] root;
        degree = clamp_degree(v);
        foreach (poly[j])
        begin
            poly[j] = '0;
        end
        poly[0] = GF_ONE;
        root = GF_ONE;
        for (int n = 0; n < degree; n++)
        begin
            for (int j = n + 1; j > 0; j--)
            begin
                poly[j] = poly[j] ^ field_mul(root, poly[j-1]);
            end
            root = field_mul(root, 8'h02);
        end
        for (int j = 0; j < MAX_EC_BYTES_DEF; j++)
        begin
            gen_taps[j] = (j < degree) ? poly[j+1] : '0;
            rem_bank[j] = '0;
        end
    endtask

    task automatic take_byte(input logic [BYTE_W-1:0] data, input logic last);
        logic [BYTE_W-1:0] fb;
        fb = data ^ rem_bank[0];
        for (int i = 0; i < degree - 1; i++)
        begin
            rem_bank[i] = rem_bank[i+1] ^ field_mul(fb, gen_taps[i]);
        end
        rem_bank[degree-1] = field_mul(fb, gen_taps[degree-1]);
        if (last)
        begin
            for (int i = 0; i < degree; i++)
            begin
                parity_queue.push_back('{ec_byte: rem_bank[i], ec_last: (i == degree - 1)});
            end
            for (int i = 0; i < MAX_EC_BYTES_DEF; i++)
            begin
                rem_bank[i] = '0;
            end
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("[%0t] ecc mismatch: %s", $time, what);
        mismatch_total++;
    endtask

    task automatic check_parity(input logic [BYTE_W-1:0] got_byte, input logic got_last);
        parity_t want;
        if (parity_queue.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected ec_byte %02h ec_last %0b", got_byte, got_last));
        end
        else
        begin
            want = parity_queue.pop_front();
            if (got_byte !== want.ec_byte)
            begin
                flag_mismatch($sformatf("ec_byte got %02h want %02h", got_byte, want.ec_byte));
            end
            if (got_last !== want.ec_last)
            begin
                flag_mismatch($sformatf("ec_last got %0b want %0b", got_last, want.ec_last));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            parity_queue.delete();
            load_degree(EC_COUNT_RESET);
        end
        else
        begin
            if (ecc.valid && ecc.ready)
            begin
                check_parity(ecc.ec_byte, ecc.ec_last);
            end
            if (cfg.valid && cfg.ready)
            begin
                load_degree(cfg.ec_count);
            end
            if (msg.valid && msg.ready)
            begin
                take_byte(msg.data_byte, msg.block_end);
            end
        end
        queue_depth <= parity_queue.size();
    end

endmodule

// ===== tb/sv/qr_reed_solomon_ec_encoder_test.sv =====
// stimulus and verdict for the qr reed-solomon error-correction encoder
module qr_reed_solomon_ec_encoder_test;
    import qrrs_pkg::*;

    logic clk;
    logic rst_n;

    // verdict inputs from the checker
    int mismatch_count;
    int parity_pending;

    // idling control shared between the sender and the receiver process
    bit idle_on = 1'b0;
    int hold_len = 0;

    qrrs_msg_if msg_ch ();
    qrrs_ecc_if ecc_ch ();
    qrrs_cfg_if cfg_ch ();

    qr_reed_solomon_ec_encoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .ecc   (ecc_ch),
        .cfg   (cfg_ch)
    );

    // predictor and scoreboard sit beside the block and only watch
    qrrs_ec_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .ecc     (ecc_ch),
        .cfg     (cfg_ch),
        .errors  (mismatch_count),
        .pending (parity_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // hard stop in case the block hangs; well beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    // ecc receiver: ready in random stretches, every change at a falling edge
    // a hold request from the stimulus becomes one long low stretch, counted here
    initial
    begin
        int lvl;
        int len;
        ecc_ch.ready = 1'b0;
        forever
        begin
            if (hold_len > 0)
            begin
                lvl = 0;
                len = hold_len;
                hold_len = 0;
            end
            else if (idle_on && ($urandom_range(0, 2) == 0))
            begin
                lvl = 0;
                len = $urandom_range(1, 17);
            end
            else
            begin
                lvl = 1;
                len = $urandom_range(1, 24);
            end
            @(negedge clk);
            ecc_ch.ready <= (lvl != 0);
            repeat (len - 1) @(negedge clk);
        end
    end

    // one message transaction, with an optional random gap in front of it
    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
        int gap;
        gap = (idle_on && ($urandom_range(0, 3) == 0)) ? $urandom_range(1, 17) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            msg_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        msg_ch.valid <= 1'b1;
        msg_ch.data_byte <= data;
        msg_ch.block_end <= last;
        @(posedge clk);
        while (!msg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // drop valid, wait until every predicted parity byte has come out,
    // then let the drain bank go quiet
    task automatic settle();
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (parity_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // cfg write; only issued once the block is idle
    task automatic write_ec_count(input logic [EC_COUNT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.ec_count <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // random blocks, mostly short, now and then long; the phase always
    // closes on a block end so the block is idle afterwards
    task automatic send_random_blocks(input int item_goal);
        int sent;
        int blk_len;
        logic [BYTE_W-1:0] data;
        sent = 0;
        while (sent < item_goal)
        begin
            blk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
            for (int k = 0; k < blk_len; k++)
            begin
                case ($urandom_range(0, 9))
                    0: data = 8'h00;
                    1: data = 8'hFF;
                    default: data = 8'($urandom_range(0, 255));
                endcase
                push_byte(data, k == blk_len - 1);
            end
            sent += blk_len;
        end
    endtask

    initial
    begin
        logic [EC_COUNT_W-1:0] ec_plan [6];

        rst_n = 1'b0;
        msg_ch.valid = 1'b0;
        msg_ch.data_byte = '0;
        msg_ch.block_end = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.ec_count = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset degree 7: one-byte blocks, byte extremes, a short block
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        settle();

        // smallest degree
        write_ec_count(6'd1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFE, 1'b1);
        settle();

        // largest degree
        write_ec_count(6'd32);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();

        // zero saturates up to one
        write_ec_count(6'd0);
        push_byte(8'hAA, 1'b1);
        push_byte(8'h55, 1'b1);
        settle();

        // all ones saturates down to the maximum
        write_ec_count(6'd63);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);
        settle();

        // just over the maximum
        write_ec_count(6'd33);
        push_byte(8'hC3, 1'b1);
        settle();

        // random phases across several degrees
        ec_plan[0] = 6'd4;
        ec_plan[1] = 6'd32;
        ec_plan[2] = 6'($urandom_range(0, 63));
        ec_plan[3] = 6'd1;
        ec_plan[4] = 6'($urandom_range(1, 12));
        ec_plan[5] = 6'd10;
        for (int p = 0; p < 6; p++)
        begin
            // idling off in one middle phase and in the final one
            idle_on = (p != 2) && (p != 5);
            write_ec_count(ec_plan[p]);
            if (p == 1)
            begin
                // long receiver hold while the sender keeps offering bytes,
                // so the drain bank stays full and msg backs up
                hold_len = 300;
            end
            send_random_blocks(30);
            settle();
        end

        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && parity_pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/qrrs_pkg.sv
hdl/qrrs_channels.sv
hdl/qr_reed_solomon_ec_encoder.sv
tb/sv/qrrs_ec_checker.sv
tb/sv/qr_reed_solomon_ec_encoder_test.sv
